// ----- rtl/ets_pkg.sv -----
// Shared types, token codes and character classes of the expression token scanner.
package ets_pkg;

    // Scanner automaton states.
    typedef enum logic [3:0] {
        MODE_IDLE     = 4'd0,
        MODE_IDENT    = 4'd1,
        MODE_NUM_INT  = 4'd2,
        MODE_NUM_DOT  = 4'd3,
        MODE_NUM_FRAC = 4'd4,
        MODE_NUM_EXP  = 4'd5,
        MODE_NUM_SIGN = 4'd6,
        MODE_NUM_EXPD = 4'd7
    } t_mode;

    // Token kind codes.
    localparam logic [4:0] KIND_IDENT   = 5'd0;
    localparam logic [4:0] KIND_COMMAND = 5'd1;
    localparam logic [4:0] KIND_NUMBER  = 5'd2;
    localparam logic [4:0] KIND_ASSIGN  = 5'd3;
    localparam logic [4:0] KIND_PLUS    = 5'd4;
    localparam logic [4:0] KIND_MINUS   = 5'd5;
    localparam logic [4:0] KIND_STAR    = 5'd6;
    localparam logic [4:0] KIND_SLASH   = 5'd7;
    localparam logic [4:0] KIND_LPAREN  = 5'd8;
    localparam logic [4:0] KIND_RPAREN  = 5'd9;
    localparam logic [4:0] KIND_LBRACK  = 5'd10;
    localparam logic [4:0] KIND_RBRACK  = 5'd11;
    localparam logic [4:0] KIND_SEMI    = 5'd12;
    localparam logic [4:0] KIND_LBRACE  = 5'd13;
    localparam logic [4:0] KIND_RBRACE  = 5'd14;
    localparam logic [4:0] KIND_COMMA   = 5'd15;
    localparam logic [4:0] KIND_END     = 5'd16;
    localparam logic [4:0] KIND_ERROR   = 5'd17;

    // Character codes the automaton looks for.
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LOW_E  = 8'h65;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // One result beat.
    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic        last;
    } t_result;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // Single-character operator decode; anything else is an error token.
    function automatic logic [4:0] op_kind(input logic [7:0] c);
        logic [4:0] k;
        unique case (c)
            CH_EQUAL:  k = KIND_ASSIGN;
            CH_PLUS:   k = KIND_PLUS;
            CH_MINUS:  k = KIND_MINUS;
            CH_STAR:   k = KIND_STAR;
            CH_SLASH:  k = KIND_SLASH;
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_LBRACK: k = KIND_LBRACK;
            CH_RBRACK: k = KIND_RBRACK;
            CH_SEMI:   k = KIND_SEMI;
            CH_LBRACE: k = KIND_LBRACE;
            CH_RBRACE: k = KIND_RBRACE;
            CH_COMMA:  k = KIND_COMMA;
            default:   k = KIND_ERROR;
        endcase
        return k;
    endfunction

endpackage

// ----- rtl/expression_token_scanner.sv -----
// Top level of the expression token scanner: input register, scanner automaton, result queue.
// A character beat is registered in the input stage and scanned from there once the result
// queue has room for two results; the results are registered in the queue, which drives the output.
// Throughput: one character per cycle while the queue has room; a character that closes a token
// and starts an operator gives two results, which leave the four-entry queue one per cycle while
// the output is ready. Reset (i_rst_n low, synchronous) empties the input stage and the queue
// and returns the automaton to idle at position zero.
module expression_token_scanner #(
    parameter int POS_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_char_code,
    input  logic        i_end_of_text,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [4:0]  o_token_kind,
    output logic [15:0] o_token_start,
    output logic [15:0] o_token_length,
    output logic        o_last_of_run
);

    localparam int WIDE    = (POS_WIDTH > 16) ? POS_WIDTH : 16;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // Input stage.
    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_eot;

    // Scanner state.
    ets_pkg::t_mode         r_mode, n_mode;
    logic [POS_WIDTH-1:0]   r_pos, n_pos;
    logic [POS_WIDTH-1:0]   r_begin, n_begin;
    logic                   r_cmd, n_cmd;

    // Result queue.
    ets_pkg::t_result       r_q [Q_DEPTH];
    logic [Q_AW-1:0]        r_wptr, r_rptr;
    logic [Q_AW:0]          r_count;

    logic                   fire;
    logic                   pop;
    logic [1:0]             push_n;
    ets_pkg::t_result       slot0, slot1;

    ets_pkg::t_result       close_res, new_res;
    logic                   close_v, new_v;
    logic                   pending, ext;
    ets_pkg::t_mode         ext_mode, m;
    logic [4:0]             close_kind;
    logic [POS_WIDTH-1:0]   len_pos;
    logic [WIDE-1:0]        len_wide, begin_wide, pos_wide;

    // The scan stage fires when the queue has room for two results.
    assign fire       = r_in_valid && (r_count <= (Q_AW+1)'(Q_DEPTH - 2));
    assign o_in_ready = !r_in_valid || fire;
    assign pop        = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_char <= i_char_code;
            r_eot  <= i_end_of_text;
        end
    end

    // Automaton state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= ets_pkg::MODE_IDLE;
            r_pos   <= '0;
            r_begin <= '0;
            r_cmd   <= 1'b0;
        end else if (fire) begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_begin <= n_begin;
            r_cmd   <= n_cmd;
        end
    end

    // The token length wraps at the position width before it is widened.
    assign len_pos    = r_pos - r_begin;
    assign len_wide   = WIDE'(len_pos);
    assign begin_wide = WIDE'(r_begin);
    assign pos_wide   = WIDE'(r_pos);
    assign pending    = (r_mode != ets_pkg::MODE_IDLE);

    // Kind of the pending token if it closes now.
    always_comb begin
        unique case (r_mode)
            ets_pkg::MODE_IDENT:
                close_kind = r_cmd ? ets_pkg::KIND_COMMAND : ets_pkg::KIND_IDENT;
            ets_pkg::MODE_NUM_INT, ets_pkg::MODE_NUM_FRAC, ets_pkg::MODE_NUM_EXPD:
                close_kind = ets_pkg::KIND_NUMBER;
            default:
                close_kind = ets_pkg::KIND_ERROR;
        endcase
    end

    // Whether the character extends the pending token, and the mode it leads to.
    always_comb begin
        ext      = 1'b0;
        ext_mode = r_mode;
        unique case (r_mode)
            ets_pkg::MODE_IDENT: begin
                ext = ets_pkg::is_letter(r_char) || ets_pkg::is_digit(r_char);
            end
            ets_pkg::MODE_NUM_INT, ets_pkg::MODE_NUM_FRAC: begin
                if (ets_pkg::is_digit(r_char)) begin
                    ext = 1'b1;
                end else if (r_char == ets_pkg::CH_DOT && r_mode == ets_pkg::MODE_NUM_INT) begin
                    ext      = 1'b1;
                    ext_mode = ets_pkg::MODE_NUM_DOT;
                end else if (r_char == ets_pkg::CH_LOW_E || r_char == ets_pkg::CH_UP_E) begin
                    ext      = 1'b1;
                    ext_mode = ets_pkg::MODE_NUM_EXP;
                end
            end
            ets_pkg::MODE_NUM_DOT: begin
                ext      = ets_pkg::is_digit(r_char);
                ext_mode = ets_pkg::MODE_NUM_FRAC;
            end
            ets_pkg::MODE_NUM_EXP: begin
                ext      = (r_char == ets_pkg::CH_PLUS) || (r_char == ets_pkg::CH_MINUS);
                ext_mode = ets_pkg::MODE_NUM_SIGN;
            end
            ets_pkg::MODE_NUM_SIGN: begin
                ext      = ets_pkg::is_digit(r_char);
                ext_mode = ets_pkg::MODE_NUM_EXPD;
            end
            ets_pkg::MODE_NUM_EXPD: begin
                ext = ets_pkg::is_digit(r_char);
            end
            default: begin
                ext = 1'b0;
            end
        endcase
    end

    // Next state and the results of the registered beat.
    always_comb begin
        n_mode  = r_mode;
        n_pos   = r_pos + POS_WIDTH'(1);
        n_begin = r_begin;
        n_cmd   = r_cmd;
        m       = r_mode;

        close_v          = 1'b0;
        close_res.kind   = close_kind;
        close_res.start  = begin_wide[15:0];
        close_res.length = len_wide[15:0];
        close_res.last   = 1'b0;

        new_v          = 1'b0;
        new_res.kind   = ets_pkg::KIND_END;
        new_res.start  = pos_wide[15:0];
        new_res.length = 16'd0;
        new_res.last   = 1'b1;

        if (r_eot) begin
            // Flush the pending token, then mark the end and start over.
            close_v = pending;
            new_v   = 1'b1;
            n_mode  = ets_pkg::MODE_IDLE;
            n_pos   = '0;
            n_begin = '0;
            n_cmd   = 1'b0;
        end else begin
            if (pending && !ext) begin
                close_v = 1'b1;
                m       = ets_pkg::MODE_IDLE;
                n_cmd   = 1'b0;
            end else if (pending) begin
                m = ext_mode;
            end
            // A character that ended a token is scanned again from idle.
            if (m == ets_pkg::MODE_IDLE) begin
                if (ets_pkg::is_letter(r_char) || r_char == ets_pkg::CH_HASH) begin
                    m       = ets_pkg::MODE_IDENT;
                    n_begin = r_pos;
                    n_cmd   = (r_char == ets_pkg::CH_HASH);
                end else if (ets_pkg::is_digit(r_char)) begin
                    m       = ets_pkg::MODE_NUM_INT;
                    n_begin = r_pos;
                    n_cmd   = 1'b0;
                end else if (!ets_pkg::is_blank(r_char)) begin
                    new_v        = 1'b1;
                    new_res.kind = ets_pkg::op_kind(r_char);
                    new_res.length = (new_res.kind == ets_pkg::KIND_ERROR) ? 16'd0 : 16'd1;
                end
            end
            n_mode = m;
        end

        if (!new_v) begin
            close_res.last = 1'b1;
        end
        slot0  = close_v ? close_res : new_res;
        slot1  = new_res;
        push_n = {1'b0, close_v} + {1'b0, new_v};
    end

    // Result queue: up to two writes and one read per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + (fire ? Q_AW'(push_n) : Q_AW'(0));
            r_rptr  <= r_rptr + (pop ? Q_AW'(1) : Q_AW'(0));
            r_count <= r_count + (fire ? (Q_AW+1)'(push_n) : (Q_AW+1)'(0))
                       - (pop ? (Q_AW+1)'(1) : (Q_AW+1)'(0));
        end
        if (fire && push_n != 2'd0) begin
            r_q[r_wptr] <= slot0;
        end
        if (fire && push_n == 2'd2) begin
            r_q[r_wptr + Q_AW'(1)] <= slot1;
        end
    end

    assign o_out_valid    = (r_count != '0);
    assign o_token_kind   = r_q[r_rptr].kind;
    assign o_token_start  = r_q[r_rptr].start;
    assign o_token_length = r_q[r_rptr].length;
    assign o_last_of_run  = r_q[r_rptr].last;

    // The queue never holds more results than it has entries.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (Q_AW+1)'(Q_DEPTH))
        else $error("result queue overflow");

    // A beat that cannot be scanned stays in the input stage.
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !fire |=> r_in_valid)
        else $error("stalled character beat was lost");

    // End of text leaves the automaton idle at position zero.
    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_eot |=> r_mode == ets_pkg::MODE_IDLE && r_pos == '0 && !r_cmd)
        else $error("scanner state not cleared after end of text");

    // Every scanned beat that yields results closes its run with a last flag.
    a_last_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && push_n != 2'd0 |-> (push_n == 2'd2 ? slot1.last && !slot0.last : slot0.last))
        else $error("run of results without a single final marker");

endmodule
